// ----- hw/rtl/priority_scheduler_with_aging_top_macros.svh -----
// Assertion macros shared by the scheduler top level.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_TOP_MACROS_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/psa_pkg.sv -----
// Types, constants and helpers shared by the scheduler modules.
`timescale 1ns / 1ps

package psa_pkg;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 10;
  localparam int REM_W  = 8;

  localparam logic [PRIO_W-1:0] PRIO_MAX  = {PRIO_W{1'b1}};
  // Done entries compare one above the largest stored priority
  localparam logic [PRIO_W:0]   DONE_PRIO = {1'b1, {PRIO_W{1'b0}}};

  localparam logic REQ_ADMIT = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] proc_priority;
    logic [REM_W-1:0]  proc_burst;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic              ran;
    logic [ID_W-1:0]   run_id;
    logic [PRIO_W-1:0] run_priority;
    logic [REM_W-1:0]  run_remaining;
    logic              finished;
    logic              none_live;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [REM_W-1:0]  remaining;
    logic              done;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic run;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } dp_status_t;

  // Effective priority: done entries lose against every live one
  function automatic logic [PRIO_W:0] eff_prio(input slot_t s);
    logic [PRIO_W:0] r;
    r = s.done ? DONE_PRIO : {1'b0, s.prio};
    return r;
  endfunction

endpackage

// ----- hw/rtl/psa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/psa_ctrl.sv -----
// Sequencer for admit and tick items: drives the datapath commands.
`timescale 1ns / 1ps

module psa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_type,
  output logic                 req_ready,
  input  psa_pkg::dp_status_t  status,
  output psa_pkg::dp_cmd_t     cmd
);

  import psa_pkg::*;

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the item
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_type == REQ_TICK) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (status.scan_end) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_RUN: begin
        cmd.run = 1'b1;
      end
      ST_RESULT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/psa_dp.sv -----
// Slot table, front entry, scan pass, run step and output register.
`timescale 1ns / 1ps

module psa_dp #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  psa_pkg::dp_cmd_t    cmd,
  output psa_pkg::dp_status_t status,
  input  psa_pkg::req_t       req,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output psa_pkg::rsp_t       rsp
);

  import psa_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  // Control state
  logic [CW-1:0] entry_count;
  logic [CW-1:0] live_count;
  logic [CW-1:0] rd_idx;
  logic          cmp_v;

  // Payload state
  logic [AW-1:0] cmp_idx;
  slot_t         front;
  rsp_t          res;
  rsp_t          res_out;

  // RAM signals
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  slot_t             mem_wdata;
  logic [SLOT_W-1:0] mem_rdata;
  slot_t             rd_slot;

  logic              admit_ok;
  logic              lower;
  logic              run_live;
  logic [REM_W-1:0]  run_rem;
  logic [PRIO_W-1:0] run_prio;
  slot_t             new_slot;

  assign rd_slot = slot_t'(mem_rdata);

  // Decode the incoming item
  assign admit_ok = (req.req_type == REQ_ADMIT) && (entry_count < FULL);
  assign new_slot = '{id: req.proc_id, prio: req.proc_priority,
                      remaining: req.proc_burst, done: 1'b0};

  // Compare fetched slot against the front entry
  assign lower = eff_prio(rd_slot) < eff_prio(front);

  // Age and run the front entry
  assign run_live = (entry_count != '0) && !front.done;
  assign run_rem  = (front.remaining != '0) ? front.remaining - 1'b1 : front.remaining;
  assign run_prio = (front.prio != PRIO_MAX) ? front.prio + 1'b1 : front.prio;

  // Table write: admits past the front, or the displaced front during a scan
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_count[AW-1:0];
    mem_wdata = new_slot;
    if (cmd.scan_step) begin
      mem_we    = cmp_v && lower;
      mem_waddr = cmp_idx;
      mem_wdata = front;
    end else if (cmd.accept) begin
      mem_we = admit_ok && (entry_count != '0);
    end
  end

  psa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (SLOT_W'(mem_wdata)),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Report progress to the sequencer
  assign status.scan_end = !(rd_idx < entry_count);
  assign status.out_free = !rsp_valid || rsp_ready;

  // Merge the live flag into the finished result
  always_comb begin
    res_out           = res;
    res_out.none_live = (live_count == '0);
  end

  // Counters, scan pipeline and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      live_count  <= '0;
      rd_idx      <= '0;
      cmp_v       <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_idx <= CW'(1);
        cmp_v  <= 1'b0;
        if (admit_ok) begin
          entry_count <= entry_count + 1'b1;
          live_count  <= live_count + 1'b1;
        end
      end
      if (cmd.scan_step) begin
        if (rd_idx < entry_count) begin
          rd_idx <= rd_idx + 1'b1;
          cmp_v  <= 1'b1;
        end else begin
          cmp_v  <= 1'b0;
        end
      end
      if (cmd.run && run_live && (run_rem == '0)) begin
        live_count <= live_count - 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Front entry, swap, result and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res <= '{accepted: admit_ok, default: '0};
      if (admit_ok && (entry_count == '0)) begin
        front <= new_slot;
      end
    end
    if (cmd.scan_step) begin
      if (rd_idx < entry_count) begin
        cmp_idx <= rd_idx[AW-1:0];
      end
      if (cmp_v && lower) begin
        front <= rd_slot;
      end
    end
    if (cmd.run && run_live) begin
      front.remaining   <= run_rem;
      front.prio        <= run_prio;
      front.done        <= (run_rem == '0);
      res.ran           <= 1'b1;
      res.run_id        <= front.id;
      res.run_priority  <= run_prio;
      res.run_remaining <= run_rem;
      res.finished      <= (run_rem == '0);
    end
    if (cmd.out_load) begin
      rsp <= res_out;
    end
  end

endmodule

// ----- hw/rtl/priority_scheduler_with_aging_top.sv -----
// Top level of the priority scheduler with aging.
`timescale 1ns / 1ps
// Usage:
//   req channel (req_valid / req_ready / req) takes one item at a time:
//   an admit appends a process to the table, a tick runs the best one.
//   rsp channel (rsp_valid / rsp_ready / rsp) returns one item per request.
// Sequence, request accept to rsp_valid:
//   admit: straight to the result state, which loads the output register.
//   tick:  scan, run, then result; the scan reads one slot a cycle
//          from the slot RAM and compares it with the front entry held in
//          registers.
// Occupancy: req_ready is high again once the result is loaded, so a new
//   item is taken only after the result of the one before has been loaded.
// Reset: rst (synchronous) empties the table and clears all handshakes;
//   slot contents are not cleared and are only read once written.
// Stall: a result waits in the output register while rsp_ready is low; the
//   next request is still taken and worked on, and its result is held back
//   until the register frees.
`include "priority_scheduler_with_aging_top_macros.svh"

module priority_scheduler_with_aging_top #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  psa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output psa_pkg::rsp_t rsp
);

  import psa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  psa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Checks on the sequencing and result consistency
  `PSA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
  `PSA_ASSERT_IMPL(a_fin_means_ran, rsp_valid && rsp.finished, rsp.ran && (rsp.run_remaining == '0), "finish without run")
  `PSA_ASSERT_IMPL(a_ran_not_admit, rsp_valid && rsp.ran, !rsp.accepted, "run and admit together")
  `PSA_ASSERT_IMPL(a_live_left, rsp_valid && rsp.ran && !rsp.finished, !rsp.none_live, "live process lost")

endmodule

// ----- sim/priority_scheduler_with_aging_top_test.sv -----
// Self-checking testbench for the aging priority scheduler: queued stimulus, checked replies.
`timescale 1ns / 1ps

module priority_scheduler_with_aging_top_test;
  import psa_pkg::*;

  localparam int SLOTS       = 8;
  localparam int SLOT_AW     = $clog2(SLOTS);
  localparam int N_RANDOM    = 1800;
  localparam int ADMIT_PCT   = 12;
  localparam int HOLD_AT     = 20;
  localparam int HOLD_LEN    = 200;
  localparam int SETTLE      = SLOTS + 8;
  localparam int CYCLE_LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  // Scheduler state as predicted from the accepted items
  slot_t proc_slot [SLOTS];
  int    slot_count = 0;

  req_t  pending_req [$];
  rsp_t  expected_rsp [$];
  rsp_t  want_rsp;
  int    total_items = 0;
  int    sent_count = 0;
  int    got_count = 0;
  int    fail_count = 0;
  int    hold_left = 0;
  bit    held_off = 1'b0;
  int    cycle_count = 0;

  priority_scheduler_with_aging_top #(
    .SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic req_t make_req(input logic kind, input logic [ID_W-1:0] id,
                                    input logic [PRIO_W-1:0] prio,
                                    input logic [REM_W-1:0] burst);
    req_t r;
    r.req_type      = kind;
    r.proc_id       = id;
    r.proc_priority = prio;
    r.proc_burst    = burst;
    return r;
  endfunction

  // Done entries rank below every live one
  function automatic logic [PRIO_W:0] rank_of(input slot_t s);
    logic [PRIO_W:0] v;
    v = s.done ? {1'b1, {PRIO_W{1'b0}}} : {1'b0, s.prio};
    return v;
  endfunction

  // Apply one item to the predicted table and return the reply it causes
  function automatic rsp_t schedule_step(input req_t r);
    rsp_t               o;
    slot_t              t;
    int                 k;
    logic [SLOT_AW-1:0] w;
    o = '0;
    if (r.req_type == REQ_ADMIT) begin
      if (slot_count < SLOTS) begin
        w                        = SLOT_AW'(slot_count);
        proc_slot[w].id          = r.proc_id;
        proc_slot[w].prio        = r.proc_priority;
        proc_slot[w].remaining   = r.proc_burst;
        proc_slot[w].done        = 1'b0;
        slot_count++;
        o.accepted = 1'b1;
      end
    end else begin
      // Pull any strictly better entry to the front, in slot order
      for (k = 1; k < slot_count; k++) begin
        if (rank_of(proc_slot[SLOT_AW'(k)]) < rank_of(proc_slot[0])) begin
          t                       = proc_slot[0];
          proc_slot[0]            = proc_slot[SLOT_AW'(k)];
          proc_slot[SLOT_AW'(k)]  = t;
        end
      end
      // Run the front entry for one tick and age it
      if (slot_count > 0 && !proc_slot[0].done) begin
        if (proc_slot[0].remaining != '0)
          proc_slot[0].remaining = proc_slot[0].remaining - 1'b1;
        if (proc_slot[0].prio != PRIO_MAX)
          proc_slot[0].prio = proc_slot[0].prio + 1'b1;
        if (proc_slot[0].remaining == '0) begin
          proc_slot[0].done = 1'b1;
          o.finished        = 1'b1;
        end
        o.ran           = 1'b1;
        o.run_id        = proc_slot[0].id;
        o.run_priority  = proc_slot[0].prio;
        o.run_remaining = proc_slot[0].remaining;
      end
    end
    o.none_live = 1'b1;
    for (k = 0; k < slot_count; k++) begin
      if (!proc_slot[SLOT_AW'(k)].done)
        o.none_live = 1'b0;
    end
    return o;
  endfunction

  // Idle percentage for the phase reached: sender 31/49/0, receiver 49/31/0
  function automatic int idle_pct(input int n, input bit sender);
    int p;
    if (n < total_items / 3)
      p = sender ? 31 : 49;
    else if (n < (2 * total_items) / 3)
      p = sender ? 49 : 31;
    else
      p = 0;
    return p;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: offer queued items, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsp.push_back(schedule_step(req));
        sent_count++;
      end
      if (!req_valid || req_ready) begin
        if (pending_req.size() > 0 && $urandom_range(0, 99) >= idle_pct(sent_count, 1'b1)) begin
          req       <= pending_req.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each reply against the oldest prediction, drive ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("reply with nothing outstanding");
          fail_count++;
        end else begin
          want_rsp = expected_rsp.pop_front();
          check_field("accepted", int'(want_rsp.accepted), int'(rsp.accepted));
          check_field("ran", int'(want_rsp.ran), int'(rsp.ran));
          check_field("run_id", int'(want_rsp.run_id), int'(rsp.run_id));
          check_field("run_priority", int'(want_rsp.run_priority),
                      int'(rsp.run_priority));
          check_field("run_remaining", int'(want_rsp.run_remaining),
                      int'(rsp.run_remaining));
          check_field("finished", int'(want_rsp.finished), int'(rsp.finished));
          check_field("none_live", int'(want_rsp.none_live), int'(rsp.none_live));
        end
        got_count++;
      end
      // Hold off once for a long stretch so the block backs up
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held_off && got_count >= HOLD_AT) begin
        held_off  <= 1'b1;
        hold_left <= HOLD_LEN;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= idle_pct(got_count, 1'b0));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int   i;
    logic kind;

    // Empty table, then a maximum-priority entry that saturates as it ages
    pending_req.push_back(make_req(REQ_TICK, 8'h00, 10'd0, 8'd0));
    pending_req.push_back(make_req(REQ_ADMIT, 8'hFF, PRIO_MAX, 8'd2));
    pending_req.push_back(make_req(REQ_TICK, 8'hFF, PRIO_MAX, 8'hFF));
    pending_req.push_back(make_req(REQ_TICK, 8'h00, 10'd0, 8'd0));
    // Only done entries left
    pending_req.push_back(make_req(REQ_TICK, 8'h00, 10'd0, 8'd0));
    // Zero burst finishes on its first run without wrapping
    pending_req.push_back(make_req(REQ_ADMIT, 8'h00, 10'd0, 8'd0));
    pending_req.push_back(make_req(REQ_TICK, 8'h00, 10'd0, 8'd0));
    // Equal priorities must not swap; longest burst
    pending_req.push_back(make_req(REQ_ADMIT, 8'h55, 10'd512, 8'hFF));
    pending_req.push_back(make_req(REQ_ADMIT, 8'hAA, 10'd512, 8'd3));
    for (i = 0; i < 4; i++)
      pending_req.push_back(make_req(REQ_TICK, 8'hFF, PRIO_MAX, 8'hFF));

    // Random mix: mostly ticks, admits fill the table and then bounce
    for (i = 0; i < N_RANDOM; i++) begin
      kind = ($urandom_range(0, 99) < ADMIT_PCT) ? REQ_ADMIT : REQ_TICK;
      pending_req.push_back(make_req(kind, ID_W'($urandom_range(0, 255)),
                                     PRIO_W'($urandom_range(0, 1023)),
                                     REM_W'($urandom_range(0, 255))));
    end
    total_items = pending_req.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_items) @(negedge clk);
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/psa_pkg.sv
hw/rtl/psa_ram.sv
hw/rtl/psa_ctrl.sv
hw/rtl/psa_dp.sv
hw/rtl/priority_scheduler_with_aging_top.sv
sim/priority_scheduler_with_aging_top_test.sv
